[rtl/core/assert_macros.svh]
// assertion macros shared by the timer core modules
// no dependencies; included by every module that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/swct_pkg.sv]
// types and constants of the stopwatch / countdown timer core
// no dependencies; imported by every module of the core
`default_nettype none

package swct_pkg;

   // fixed field widths
   localparam int REG_W       = 27;
   localparam int FUNC_W      = 3;
   localparam int ELAPSED_W   = 16;
   localparam int REST_W      = 17;
   localparam int CSR_INDEX_W = 2;

   // one minute is 60000 ms = 2^5 * 1875
   localparam int MS_PER_MIN = 60000;
   localparam int MIN_SHIFT  = 5;
   localparam int DIV_ODD    = 1875;
   localparam int DIV_ODD_W  = 11;

   // register reset values
   localparam logic signed [REG_W-1:0] START_VALUE_RESET = REG_W'(0);
   localparam logic signed [REG_W-1:0] MIN_LIMIT_RESET   = REG_W'(-100);
   localparam logic signed [REG_W-1:0] MAX_LIMIT_RESET   = REG_W'(35000000);

   // command codes
   typedef enum logic [FUNC_W-1:0] {
      FN_TICK      = 3'd0,
      FN_START     = 3'd1,
      FN_STOP      = 3'd2,
      FN_RESET     = 3'd3,
      FN_INCREMENT = 3'd4,
      FN_INQUIRE   = 3'd5
   } func_type;

   // result event codes
   typedef enum logic [1:0] {
      EVT_NONE    = 2'd0,
      EVT_LIMIT   = 2'd1,
      EVT_INQUIRY = 2'd2
   } evt_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_VALUE = 2'd0,
      CSR_MIN_LIMIT   = 2'd1,
      CSR_MAX_LIMIT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [REG_W-1:0] start_value;
      logic signed [REG_W-1:0] min_limit;
      logic signed [REG_W-1:0] max_limit;
   } cfg_type;

   typedef struct packed {
      logic    running;
      evt_type evt;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/swct_csr.sv]
// configuration registers of the timer core: start value and the two limits
// depends on swct_pkg
`default_nettype none

module swct_csr import swct_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [REG_W-1:0]        csr_wdata,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value <= START_VALUE_RESET;
         cfg_ff.min_limit   <= MIN_LIMIT_RESET;
         cfg_ff.max_limit   <= MAX_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_VALUE: cfg_ff.start_value <= $signed(csr_wdata);
            CSR_MIN_LIMIT:   cfg_ff.min_limit   <= $signed(csr_wdata);
            CSR_MAX_LIMIT:   cfg_ff.max_limit   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/swct_cmd.sv]
// command execution: timer state, saturating update, limit check and first result stage
// depends on swct_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module swct_cmd import swct_pkg::*; #(
   parameter int TIME_WIDTH = 27
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cfg_type                      cfg,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [FUNC_W-1:0]            req_func,
   input  wire logic [ELAPSED_W-1:0]         req_elapsed_ms,
   input  wire logic signed [REG_W-1:0]      req_amount_ms,
   output logic                              s1_valid,
   output logic signed [TIME_WIDTH-1:0]      s1_time,
   output status_type                        s1_status,
   input  wire logic                         down_ready
);

   // working width holds both the time range and the register range with headroom
   localparam int CW = ((TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W) + 2;
   localparam logic signed [CW-1:0] T_MAX =
      {{(CW-TIME_WIDTH+1){1'b0}}, {(TIME_WIDTH-1){1'b1}}};
   localparam logic signed [CW-1:0] T_MIN =
      {{(CW-TIME_WIDTH+1){1'b1}}, {(TIME_WIDTH-1){1'b0}}};

   logic signed [TIME_WIDTH-1:0] time_ff, time_in;
   logic                         running_ff, running_in;
   logic                         s1_valid_ff;
   logic signed [TIME_WIDTH-1:0] s1_time_ff;
   status_type                   s1_status_ff;

   func_type                     fn;
   logic                         s1_ready;
   logic                         accept;
   logic                         countdown;
   logic                         limit_hit;
   logic signed [CW-1:0]         time_ext, elapsed_ext, amount_ext, start_ext;
   logic signed [CW-1:0]         min_ext, max_ext;
   logic signed [CW-1:0]         start_abs, addend, upd_sum, cand, clamped, check_time;
   evt_type                      evt;

   assign fn        = func_type'(req_func);
   assign s1_ready  = !s1_valid_ff || down_ready;
   assign req_stall = reset || !s1_ready;
   assign accept    = req_valid && !req_stall;
   assign countdown = cfg.start_value[REG_W-1];

   // operands extended to the working width
   assign time_ext    = $signed({{(CW-TIME_WIDTH){time_ff[TIME_WIDTH-1]}}, time_ff});
   assign elapsed_ext = $signed({{(CW-ELAPSED_W){1'b0}}, req_elapsed_ms});
   assign amount_ext  = $signed({{(CW-REG_W){req_amount_ms[REG_W-1]}}, req_amount_ms});
   assign start_ext   =
      $signed({{(CW-REG_W){cfg.start_value[REG_W-1]}}, cfg.start_value});
   assign min_ext     = $signed({{(CW-REG_W){cfg.min_limit[REG_W-1]}}, cfg.min_limit});
   assign max_ext     = $signed({{(CW-REG_W){cfg.max_limit[REG_W-1]}}, cfg.max_limit});

   // one shared adder for tick and increment, then saturation to the time range
   always_comb begin
      start_abs = countdown ? -start_ext : start_ext;
      if (fn == FN_INCREMENT) begin
         addend = amount_ext;
      end else begin
         addend = countdown ? -elapsed_ext : elapsed_ext;
      end
      upd_sum = time_ext + addend;
      cand    = (fn == FN_RESET) ? start_abs : upd_sum;
      if (cand > T_MAX) begin
         clamped = T_MAX;
      end else if (cand < T_MIN) begin
         clamped = T_MIN;
      end else begin
         clamped = cand;
      end
   end

   // limit check sees the time after this tick
   assign check_time = running_ff ? clamped : time_ext;
   assign limit_hit  = (check_time <= min_ext) || (check_time >= max_ext);

   // next state and event of the command
   always_comb begin
      time_in    = time_ff;
      running_in = running_ff;
      evt        = EVT_NONE;
      case (fn)
         FN_TICK: begin
            if (running_ff) begin
               time_in = clamped[TIME_WIDTH-1:0];
            end
            if (limit_hit) begin
               running_in = 1'b0;
               evt        = EVT_LIMIT;
            end
         end
         FN_START: running_in = 1'b1;
         FN_STOP:  running_in = 1'b0;
         FN_RESET: time_in = clamped[TIME_WIDTH-1:0];
         FN_INCREMENT: begin
            if (running_ff) begin
               time_in = clamped[TIME_WIDTH-1:0];
            end
         end
         FN_INQUIRE: evt = EVT_INQUIRY;
         default: ;
      endcase
   end

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         running_ff <= 1'b0;
      end else if (accept) begin
         time_ff    <= time_in;
         running_ff <= running_in;
      end
   end

   // first result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_time_ff           <= time_in;
         s1_status_ff.running <= running_in;
         s1_status_ff.evt     <= evt;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_time   = s1_time_ff;
   assign s1_status = s1_status_ff;

   // a limit event always reports a stopped timer
   `ASSERT_IMPLIES(a_limit_stopped, clock, reset,
      s1_valid_ff && (s1_status_ff.evt == EVT_LIMIT), !s1_status_ff.running,
      "limit event with timer still running")

   // a stop command leaves the timer stopped
   `ASSERT_NEXT(a_stop_clears, clock, reset,
      accept && (fn == FN_STOP), !running_ff,
      "timer running after stop")

   // the first stage result mirrors the state it was taken from
   `ASSERT_NEXT(a_stage_matches_state, clock, reset,
      accept, s1_valid_ff && (s1_time_ff == time_ff) && (s1_status_ff.running == running_ff),
      "first stage differs from timer state")

endmodule

`default_nettype wire

[rtl/core/swct_split.sv]
// minute split pipeline: magnitude, reciprocal multiply in partial products,
// correction and sign, ending in the output register; depends on swct_pkg
`default_nettype none
`include "assert_macros.svh"

module swct_split import swct_pkg::*; #(
   parameter int TIME_WIDTH = 27
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          s1_valid,
   input  wire logic signed [TIME_WIDTH-1:0]  s1_time,
   input  wire status_type                    s1_status,
   output logic                               up_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [TIME_WIDTH-1:0]       rsp_time_ms,
   output logic signed [TIME_WIDTH-16:0]      rsp_whole_minutes,
   output logic signed [REST_W-1:0]           rsp_rest_ms,
   output logic                               rsp_is_running,
   output logic [1:0]                         rsp_event_res
);

   // magnitude shifted by 2^5 is divided by 1875 through a scaled reciprocal
   localparam int N_W   = TIME_WIDTH - MIN_SHIFT;
   localparam int S_SH  = N_W + DIV_ODD_W;
   localparam int M_W   = N_W + 1;
   localparam int P_W   = N_W + M_W;
   localparam int Q_W   = N_W - 10;
   localparam int HN    = (N_W + 1) / 2;
   localparam int HM    = (M_W + 1) / 2;
   localparam int MIN_W = TIME_WIDTH - 15;
   localparam int R_W   = DIV_ODD_W + 1;
   localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << S_SH) / 64'(DIV_ODD));

   logic out_ready, s3_ready, s2_ready;

   // stage 2 registers
   logic                          s2_valid_ff;
   logic signed [TIME_WIDTH-1:0]  s2_time_ff;
   status_type                    s2_status_ff;
   logic [N_W-1:0]                s2_n_ff;
   logic [MIN_SHIFT-1:0]          s2_low_ff;
   logic                          s2_neg_ff;
   logic [HN+HM-1:0]              s2_pp_ll_ff;
   logic [HN+M_W-HM-1:0]          s2_pp_lh_ff;
   logic [N_W-HN+HM-1:0]          s2_pp_hl_ff;
   logic [N_W-HN+M_W-HM-1:0]      s2_pp_hh_ff;

   // stage 3 registers
   logic                          s3_valid_ff;
   logic signed [TIME_WIDTH-1:0]  s3_time_ff;
   status_type                    s3_status_ff;
   logic [N_W-1:0]                s3_n_ff;
   logic [MIN_SHIFT-1:0]          s3_low_ff;
   logic                          s3_neg_ff;
   logic [Q_W-1:0]                s3_q0_ff;

   // output registers
   logic                          out_valid_ff;
   logic signed [TIME_WIDTH-1:0]  out_time_ff;
   logic signed [MIN_W-1:0]       out_minutes_ff;
   logic signed [REST_W-1:0]      out_rest_ff;
   status_type                    out_status_ff;

   logic [TIME_WIDTH-1:0]         mag;
   logic [N_W-1:0]                mag_n;
   logic [P_W-1:0]                psum;
   logic [N_W:0]                  qprod;
   logic [N_W:0]                  rem_full;
   logic [R_W-1:0]                rem0;
   logic                          corr;
   logic [Q_W-1:0]                q_fix;
   logic [R_W-1:0]                r_fix;
   logic [REST_W-2:0]             rest_mag;
   logic signed [MIN_W-1:0]       minutes;
   logic signed [REST_W-1:0]      rest;

   // stall chain back from the result side
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign up_ready  = s2_ready;

   // magnitude of the time, the most negative value maps to 2^(w-1)
   assign mag   = s1_time[TIME_WIDTH-1] ? (~s1_time + 1'b1) : s1_time;
   assign mag_n = mag[TIME_WIDTH-1:MIN_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid;
      end
   end

   // stage 2: four partial products of magnitude times reciprocal
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         s2_time_ff   <= s1_time;
         s2_status_ff <= s1_status;
         s2_n_ff      <= mag_n;
         s2_low_ff    <= mag[MIN_SHIFT-1:0];
         s2_neg_ff    <= s1_time[TIME_WIDTH-1];
         s2_pp_ll_ff  <= mag_n[HN-1:0] * RECIP[HM-1:0];
         s2_pp_lh_ff  <= mag_n[HN-1:0] * RECIP[M_W-1:HM];
         s2_pp_hl_ff  <= mag_n[N_W-1:HN] * RECIP[HM-1:0];
         s2_pp_hh_ff  <= mag_n[N_W-1:HN] * RECIP[M_W-1:HM];
      end
   end

   // stage 3: sum of the partial products gives a quotient estimate
   assign psum = P_W'(s2_pp_ll_ff)
               + (P_W'(s2_pp_lh_ff) << HM)
               + (P_W'(s2_pp_hl_ff) << HN)
               + (P_W'(s2_pp_hh_ff) << (HN + HM));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_time_ff   <= s2_time_ff;
         s3_status_ff <= s2_status_ff;
         s3_n_ff      <= s2_n_ff;
         s3_low_ff    <= s2_low_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_q0_ff     <= psum[P_W-1:S_SH];
      end
   end

   // estimate is exact or one low: one compare and subtract fixes it
   assign qprod    = (N_W+1)'(s3_q0_ff) * (N_W+1)'(DIV_ODD);
   assign rem_full = {1'b0, s3_n_ff} - qprod;
   assign rem0     = rem_full[R_W-1:0];
   assign corr     = rem0 >= R_W'(DIV_ODD);
   assign q_fix    = s3_q0_ff + Q_W'(corr);
   assign r_fix    = corr ? (rem0 - R_W'(DIV_ODD)) : rem0;
   assign rest_mag = {r_fix[DIV_ODD_W-1:0], s3_low_ff};

   // both parts carry the sign of the time
   assign minutes = s3_neg_ff ? -$signed(q_fix) : $signed(q_fix);
   assign rest    = s3_neg_ff ? -$signed({1'b0, rest_mag}) : $signed({1'b0, rest_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         out_time_ff    <= s3_time_ff;
         out_minutes_ff <= minutes;
         out_rest_ff    <= rest;
         out_status_ff  <= s3_status_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_time_ms       = out_time_ff;
   assign rsp_whole_minutes = out_minutes_ff;
   assign rsp_rest_ms       = out_rest_ff;
   assign rsp_is_running    = out_status_ff.running;
   assign rsp_event_res     = out_status_ff.evt;

   // reciprocal estimate is never more than one below the true quotient
   `ASSERT_IMPLIES(a_estimate_close, clock, reset,
      s3_valid_ff, (rem_full < (N_W+1)'(2 * DIV_ODD)),
      "quotient estimate off by more than one")

   // remainder stays within one minute
   `ASSERT_IMPLIES(a_rest_range, clock, reset,
      out_valid_ff,
      (out_rest_ff < REST_W'(MS_PER_MIN)) && (out_rest_ff > -REST_W'(MS_PER_MIN)),
      "remainder outside one minute")

   // a nonzero remainder has the sign of the time
   `ASSERT_IMPLIES(a_rest_sign, clock, reset,
      out_valid_ff && (out_rest_ff != '0),
      out_rest_ff[REST_W-1] == out_time_ff[TIME_WIDTH-1],
      "remainder sign differs from time sign")

endmodule

`default_nettype wire

[rtl/core/stopwatch_countdown_timer_core.sv]
// stopwatch / countdown timer core: an accepted command word passes the first
// result stage, stages 2 and 3 and the output register; one word accepted every
// cycle while not stalled, set by the state update loop; the later stages halt
// only on result stall; synchronous active-high reset: timer stopped at zero,
// registers at reset values, pipeline empty; no clearing pass
`default_nettype none

module stopwatch_countdown_timer_core import swct_pkg::*; #(
   parameter int TIME_WIDTH = 27
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [REG_W-1:0]              csr_wdata,
   // command words
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [FUNC_W-1:0]             req_func,
   input  wire logic [ELAPSED_W-1:0]          req_elapsed_ms,
   input  wire logic signed [REG_W-1:0]       req_amount_ms,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [TIME_WIDTH-1:0]       rsp_time_ms,
   output logic signed [TIME_WIDTH-16:0]      rsp_whole_minutes,
   output logic signed [REST_W-1:0]           rsp_rest_ms,
   output logic                               rsp_is_running,
   output logic [1:0]                         rsp_event_res
);

   cfg_type                      cfg;
   logic                         s1_valid;
   logic signed [TIME_WIDTH-1:0] s1_time;
   status_type                   s1_status;
   logic                         down_ready;

   swct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swct_cmd #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_cmd (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_elapsed_ms (req_elapsed_ms),
      .req_amount_ms  (req_amount_ms),
      .s1_valid       (s1_valid),
      .s1_time        (s1_time),
      .s1_status      (s1_status),
      .down_ready     (down_ready)
   );

   swct_split #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_split (
      .clock             (clock),
      .reset             (reset),
      .s1_valid          (s1_valid),
      .s1_time           (s1_time),
      .s1_status         (s1_status),
      .up_ready          (down_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_time_ms       (rsp_time_ms),
      .rsp_whole_minutes (rsp_whole_minutes),
      .rsp_rest_ms       (rsp_rest_ms),
      .rsp_is_running    (rsp_is_running),
      .rsp_event_res     (rsp_event_res)
   );

endmodule

`default_nettype wire

[test/tb_stopwatch_countdown_timer_core.sv]
// self-checking testbench for the stopwatch / countdown timer core
// depends on swct_pkg and stopwatch_countdown_timer_core; drives command words, predicts
// every result word in its own timer model and compares field by field
`default_nettype none

module tb_stopwatch_countdown_timer_core;
   import swct_pkg::*;

   localparam int TIME_W       = 27;
   localparam int MIN_W        = TIME_W - 15;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PRESSURE_LEN = 300;
   localparam int PHASE_WORDS  = 240;
   localparam int PHASES       = 8;

   // command codes the core leaves undefined
   localparam logic [FUNC_W-1:0] FN_SPARE_SIX   = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_SEVEN = 3'd7;

   localparam logic signed [REG_W-1:0] REG_MOST_NEG = {1'b1, {(REG_W-1){1'b0}}};
   localparam logic signed [REG_W-1:0] REG_MOST_POS = {1'b0, {(REG_W-1){1'b1}}};

   typedef struct {
      logic [FUNC_W-1:0]       func;
      logic [ELAPSED_W-1:0]    elapsed;
      logic signed [REG_W-1:0] amount;
   } timer_cmd_type;

   typedef struct {
      logic signed [TIME_W-1:0] time_ms;
      logic signed [MIN_W-1:0]  minutes;
      logic signed [REST_W-1:0] rest;
      logic                     running;
      logic [1:0]               evt;
   } timer_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [REG_W-1:0]         csr_wdata = '0;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [ELAPSED_W-1:0]     req_elapsed_ms = '0;
   logic signed [REG_W-1:0]  req_amount_ms = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [TIME_W-1:0] rsp_time_ms;
   logic signed [MIN_W-1:0]  rsp_whole_minutes;
   logic signed [REST_W-1:0] rsp_rest_ms;
   logic                     rsp_is_running;
   logic [1:0]               rsp_event_res;

   stopwatch_countdown_timer_core #(
      .TIME_WIDTH (TIME_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_elapsed_ms    (req_elapsed_ms),
      .req_amount_ms     (req_amount_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_time_ms       (rsp_time_ms),
      .rsp_whole_minutes (rsp_whole_minutes),
      .rsp_rest_ms       (rsp_rest_ms),
      .rsp_is_running    (rsp_is_running),
      .rsp_event_res     (rsp_event_res)
   );

   // clock
   always #5 clock = ~clock;

   // timer model state and its copy of the registers
   longint tmr_value;
   bit     tmr_running;
   longint set_start;
   longint set_floor;
   longint set_ceiling;

   timer_cmd_type     command_backlog[$];
   timer_reading_type awaited_readings[$];
   timer_cmd_type     driven_cmd;

   bit          req_taken;
   bit          rsp_taken;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          tx_gap;
   int          rx_wait;
   int          rx_hold;
   int unsigned hold_seq;
   int unsigned hold_seen;
   int          mismatches;
   int          cycles;

   function automatic longint clamp_to_range(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (TIME_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // timer reading after one command word, updating the model state
   function automatic timer_reading_type advance_timer(timer_cmd_type c);
      timer_reading_type r;
      longint            mins;
      logic [1:0]        ev;
      ev = EVT_NONE;
      case (c.func)
         FN_TICK: begin
            if (tmr_running) begin
               if (set_start < 0) tmr_value = clamp_to_range(tmr_value - longint'(c.elapsed));
               else tmr_value = clamp_to_range(tmr_value + longint'(c.elapsed));
            end
            if (tmr_value <= set_floor || tmr_value >= set_ceiling) begin
               tmr_running = 1'b0;
               ev = EVT_LIMIT;
            end
         end
         FN_START: tmr_running = 1'b1;
         FN_STOP: tmr_running = 1'b0;
         FN_RESET: tmr_value = clamp_to_range(set_start < 0 ? -set_start : set_start);
         FN_INCREMENT: begin
            if (tmr_running) tmr_value = clamp_to_range(tmr_value + longint'(c.amount));
         end
         FN_INQUIRE: ev = EVT_INQUIRY;
         default: ;
      endcase
      mins = tmr_value / MS_PER_MIN;
      r.time_ms = TIME_W'(tmr_value);
      r.minutes = MIN_W'(mins);
      r.rest    = REST_W'(tmr_value - mins * MS_PER_MIN);
      r.running = tmr_running;
      r.evt     = ev;
      return r;
   endfunction

   function automatic logic signed [REG_W-1:0] random_reg_value();
      case ($urandom_range(0, 4))
         0: return REG_MOST_NEG;
         1: return REG_MOST_POS;
         2: return REG_W'($urandom);
         3: return REG_W'($urandom_range(0, 2000000));
         default: return REG_W'(-longint'($urandom_range(0, 2000000)));
      endcase
   endfunction

   // mostly ticks and increments with short elapsed times, so limits are reached
   function automatic timer_cmd_type random_command();
      timer_cmd_type c;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) c.func = FN_TICK;
      else if (pick < 55) c.func = FN_START;
      else if (pick < 60) c.func = FN_STOP;
      else if (pick < 68) c.func = FN_RESET;
      else if (pick < 80) c.func = FN_INCREMENT;
      else if (pick < 93) c.func = FN_INQUIRE;
      else c.func = $urandom_range(0, 1) ? FN_SPARE_SIX : FN_SPARE_SEVEN;
      c.elapsed = ($urandom_range(0, 3) == 0) ? ELAPSED_W'($urandom)
                                              : ELAPSED_W'($urandom_range(0, 2000));
      case ($urandom_range(0, 5))
         0: c.amount = REG_W'($urandom);
         1: c.amount = $urandom_range(0, 1) ? REG_MOST_NEG : REG_MOST_POS;
         2, 3: c.amount = REG_W'($urandom_range(0, 300000));
         default: c.amount = REG_W'(-longint'($urandom_range(0, 300000)));
      endcase
      return c;
   endfunction

   task automatic push_cmd(logic [FUNC_W-1:0] f, logic [ELAPSED_W-1:0] el,
                           logic signed [REG_W-1:0] am);
      timer_cmd_type c;
      c.func    = f;
      c.elapsed = el;
      c.amount  = am;
      command_backlog.push_back(c);
   endtask

   // register write, only while the core is idle
   task automatic write_csr(csr_index_type idx, logic signed [REG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_START_VALUE: set_start = value;
         CSR_MIN_LIMIT: set_floor = value;
         CSR_MAX_LIMIT: set_ceiling = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every word is sent and every result has come back
   task automatic drain_pipeline();
      do @(posedge clock);
      while (command_backlog.size() != 0 || req_valid || awaited_readings.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // command driver: holds a stalled word, otherwise idles or sends the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // word still waiting for acceptance
      end else if (tx_gap > 0) begin
         tx_gap = tx_gap - 1;
         req_valid <= 1'b0;
      end else if (command_backlog.size() != 0) begin
         driven_cmd = command_backlog.pop_front();
         req_func       <= driven_cmd.func;
         req_elapsed_ms <= driven_cmd.elapsed;
         req_amount_ms  <= driven_cmd.amount;
         req_valid      <= 1'b1;
         if (tx_idle_on && $urandom_range(0, 2) != 0) tx_gap = $urandom_range(0, 14);
         else tx_gap = 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver: random stall per word, plus a long hold-off on request
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_stall <= 1'b1;
      end else if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         rx_hold = PRESSURE_LEN - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_taken)
            rx_wait = (rx_idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
         if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: predicts accepted words and checks accepted results
   always @(posedge clock) begin
      timer_reading_type want;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken) awaited_readings.push_back(advance_timer(driven_cmd));
      if (rsp_taken) begin
         if (awaited_readings.size() == 0) begin
            $error("result word with no command outstanding: time_ms %0d", rsp_time_ms);
            mismatches++;
         end else begin
            want = awaited_readings.pop_front();
            if (rsp_time_ms !== want.time_ms) begin
               $error("time_ms expected %0d got %0d", want.time_ms, rsp_time_ms);
               mismatches++;
            end
            if (rsp_whole_minutes !== want.minutes) begin
               $error("whole_minutes expected %0d got %0d", want.minutes, rsp_whole_minutes);
               mismatches++;
            end
            if (rsp_rest_ms !== want.rest) begin
               $error("rest_ms expected %0d got %0d", want.rest, rsp_rest_ms);
               mismatches++;
            end
            if (rsp_is_running !== want.running) begin
               $error("is_running expected %0d got %0d", want.running, rsp_is_running);
               mismatches++;
            end
            if (rsp_event_res !== want.evt) begin
               $error("event_res expected %0d got %0d", want.evt, rsp_event_res);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      tmr_value   = 0;
      tmr_running = 1'b0;
      set_start   = START_VALUE_RESET;
      set_floor   = MIN_LIMIT_RESET;
      set_ceiling = MAX_LIMIT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: stopped behaviour, saturation at both ends, spare codes
      push_cmd(FN_INQUIRE, 0, 0);
      push_cmd(FN_TICK, 16'hFFFF, 0);
      push_cmd(FN_INCREMENT, 0, 5000);
      push_cmd(FN_START, 0, 0);
      push_cmd(FN_TICK, 16'hFFFF, 0);
      push_cmd(FN_TICK, 0, 0);
      push_cmd(FN_INCREMENT, 0, REG_MOST_POS);
      push_cmd(FN_TICK, 1, 0);
      push_cmd(FN_RESET, 0, 0);
      push_cmd(FN_START, 0, 0);
      push_cmd(FN_INCREMENT, 0, REG_MOST_NEG);
      push_cmd(FN_TICK, 1000, 0);
      push_cmd(FN_SPARE_SIX, 16'hFFFF, REG_MOST_NEG);
      push_cmd(FN_SPARE_SEVEN, 0, REG_MOST_POS);
      push_cmd(FN_STOP, 0, 0);
      drain_pipeline();

      // most negative start value: countdown, reset saturates to the top
      write_csr(CSR_START_VALUE, REG_MOST_NEG);
      write_csr(CSR_MIN_LIMIT, REG_MOST_NEG);
      write_csr(CSR_MAX_LIMIT, REG_MOST_POS);
      push_cmd(FN_RESET, 0, 0);
      push_cmd(FN_START, 0, 0);
      push_cmd(FN_TICK, 16'hFFFF, 0);
      push_cmd(FN_INCREMENT, 0, -1000000);
      push_cmd(FN_INQUIRE, 0, 0);
      push_cmd(FN_TICK, 0, 0);
      push_cmd(FN_STOP, 0, 0);
      drain_pipeline();

      // inverted limit window: every tick hits a limit
      write_csr(CSR_START_VALUE, REG_MOST_POS);
      write_csr(CSR_MIN_LIMIT, 0);
      write_csr(CSR_MAX_LIMIT, -1);
      push_cmd(FN_RESET, 0, 0);
      push_cmd(FN_TICK, 5, 0);
      push_cmd(FN_INQUIRE, 0, 0);
      drain_pipeline();

      // random phases, each with fresh registers and its own idling pattern
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_START_VALUE, random_reg_value());
         write_csr(CSR_MIN_LIMIT, $urandom_range(0, 1) ?
                   REG_W'(-longint'($urandom_range(0, 300000))) : random_reg_value());
         write_csr(CSR_MAX_LIMIT, $urandom_range(0, 1) ?
                   REG_W'($urandom_range(0, 3000000)) : random_reg_value());
         tx_idle_on = !(p == 1 || p == 2 || p == 5);
         rx_idle_on = !(p == 3 || p == 5);
         // back-pressure run: receiver holds off while the sender keeps offering
         if (p == 2) hold_seq++;
         for (int n = 0; n < PHASE_WORDS; n++) command_backlog.push_back(random_command());
         drain_pipeline();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
